### design/mdra_pkg.sv
// Shared constants and types for the row-major multidimensional array store.
package mdra_pkg;

  localparam int NumDims    = 8;
  localparam int DimW       = $clog2(NumDims);
  localparam int IdxW       = 12;
  localparam int BoundW     = 13;
  localparam int ElemW      = 32;
  localparam int StoreDepth = 4096;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ProdW      = BoundW + IdxW;
  localparam int PairW      = ProdW + 1;
  localparam int OffW       = ProdW + DimW;
  localparam int StatW      = 2;
  localparam int InDataW    = ((NumDims * IdxW + ElemW + 7) / 8) * 8;
  localparam int OutDataW   = ((ElemW + AddrW + 7) / 8) * 8;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_OOB   = 2'd1;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd2;

  typedef logic [BoundW-1:0] bound_t;
  typedef logic [IdxW-1:0]   index_t;
  typedef logic [ProdW-1:0]  prod_t;

endpackage

### design/multidim_array_row_major_access_top.sv
// Row-major element store for arrays of up to eight dimensions.
//
// Each access word passes through a chain of registers in order. The stride
// products are registered when the word is accepted. Then come two adder levels,
// the store access with the registered read data of the single-port element
// memory, and the output register. A new word is accepted only after the
// result has been loaded into the output register, so the store handles one
// word at a time. A held result stalls the next word at the output register.
// A bound write loads one bound and then starts a stride rebuild, one shared
// multiply and saturate for each stored stride. No access word is accepted
// during the write or the rebuild. The element memory is not cleared.
module multidim_array_row_major_access_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mdra_pkg::DimW-1:0]     cfg_idx_i,
  input  logic [mdra_pkg::BoundW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // index_0 .. index_7, write_value
  input  logic [mdra_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_value, element_offset, zero fill
  output logic [mdra_pkg::OutDataW-1:0] m_axis_tdata,
  // status
  output logic [mdra_pkg::StatW-1:0]    m_axis_tuser
);
  import mdra_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM1 = 3'd1;
  localparam logic [2:0] S_SUM2 = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  bound_t               bound_q  [NumDims];
  bound_t               stride_q [NumDims-1];
  bound_t               stride_w [NumDims];
  bound_t               run_q, run_d;
  logic                 rc_busy_q;
  logic [DimW-1:0]      rc_cnt_q, rc_nxt;
  logic [2*BoundW-1:0]  rc_prod;

  logic [2:0]           state_q;
  prod_t                prod_q [NumDims];
  prod_t                prod_d [NumDims];
  logic [PairW-1:0]     part_q [NumDims/2];
  logic [OffW-1:0]      off_q, off_d;
  logic                 oob_q, oob_d;
  logic                 op_q;
  logic [ElemW-1:0]     val_q;
  logic [StatW-1:0]     stat_q;

  logic [ElemW-1:0]     mem_q [StoreDepth];
  logic [ElemW-1:0]     rdata_q;
  logic                 mem_we, mem_re;
  logic                 s_fire, out_load;

  logic [ElemW-1:0]     rv_q;
  logic [AddrW-1:0]     eo_q;
  logic [StatW-1:0]     st_q;
  logic                 mvalid_q;

  assign s_axis_tready = (state_q == S_IDLE) && !rc_busy_q && !cfg_we_i;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int d = 0; d < NumDims - 1; d++) begin
      stride_w[d] = stride_q[d];
    end
    stride_w[NumDims-1] = BoundW'(1);
  end

  always_comb begin
    oob_d = 1'b0;
    for (int d = 0; d < NumDims; d++) begin
      prod_d[d] = ProdW'(stride_w[d]) * ProdW'(s_axis_tdata[d*IdxW +: IdxW]);
      if ({1'b0, s_axis_tdata[d*IdxW +: IdxW]} >= bound_q[d]) begin
        oob_d = 1'b1;
      end
    end
  end

  assign rc_nxt  = rc_cnt_q + DimW'(1);
  assign rc_prod = (2*BoundW)'(bound_q[rc_nxt]) * (2*BoundW)'(run_q);
  assign run_d   = (rc_prod > (2*BoundW)'(StoreDepth)) ? BoundW'(StoreDepth)
                                                       : rc_prod[BoundW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NumDims; d++) begin
        bound_q[d] <= BoundW'(1);
      end
      for (int d = 0; d < NumDims - 1; d++) begin
        stride_q[d] <= BoundW'(1);
      end
      run_q     <= BoundW'(1);
      rc_busy_q <= 1'b0;
      rc_cnt_q  <= '0;
    end else if (cfg_we_i) begin
      bound_q[cfg_idx_i] <= cfg_data_i;
      run_q              <= BoundW'(1);
      rc_busy_q          <= 1'b1;
      rc_cnt_q           <= DimW'(NumDims - 2);
    end else if (rc_busy_q) begin
      stride_q[rc_cnt_q] <= run_d;
      run_q              <= run_d;
      if (rc_cnt_q == '0) begin
        rc_busy_q <= 1'b0;
      end else begin
        rc_cnt_q <= rc_cnt_q - DimW'(1);
      end
    end
  end

  assign off_d = OffW'(part_q[0]) + OffW'(part_q[1]) + OffW'(part_q[2])
               + OffW'(part_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            state_q <= S_SUM1;
          end
        end
        S_SUM1: state_q <= S_SUM2;
        S_SUM2: state_q <= S_MEM;
        S_MEM:  state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      prod_q <= prod_d;
      oob_q  <= oob_d;
      op_q   <= s_axis_tuser;
      val_q  <= s_axis_tdata[NumDims*IdxW +: ElemW];
    end
    if (state_q == S_SUM1) begin
      for (int k = 0; k < NumDims / 2; k++) begin
        part_q[k] <= PairW'(prod_q[2*k]) + PairW'(prod_q[2*k+1]);
      end
    end
    if (state_q == S_SUM2) begin
      off_q <= off_d;
      if (oob_q) begin
        stat_q <= STAT_OOB;
      end else if (off_d >= OffW'(StoreDepth)) begin
        stat_q <= STAT_RANGE;
      end else begin
        stat_q <= STAT_OK;
      end
    end
  end

  assign mem_we = (state_q == S_MEM) && (stat_q == STAT_OK) && (op_q == OP_WRITE);
  assign mem_re = (state_q == S_MEM) && (stat_q == STAT_OK) && (op_q == OP_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[off_q[AddrW-1:0]] <= val_q;
    end
    if (mem_re) begin
      rdata_q <= mem_q[off_q[AddrW-1:0]];
    end
  end

  assign out_load = (state_q == S_OUT) && (!mvalid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (out_load) begin
      mvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      st_q <= stat_q;
      if (stat_q == STAT_OK) begin
        eo_q <= off_q[AddrW-1:0];
        rv_q <= (op_q == OP_READ) ? rdata_q : '0;
      end else begin
        eo_q <= '0;
        rv_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tuser  = st_q;
  assign m_axis_tdata  = {{(OutDataW - ElemW - AddrW){1'b0}}, eo_q, rv_q};

  a_no_accept_in_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_busy_q |-> !s_axis_tready)
    else $error("access accepted during stride rebuild");

  a_accept_starts_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == S_SUM1))
    else $error("accepted word did not enter the adder stages");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (off_q < OffW'(StoreDepth)) && !oob_q)
    else $error("store written at a rejected offset");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && (st_q != STAT_OK)) |-> (rv_q == '0) && (eo_q == '0))
    else $error("error word carries nonzero payload");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && !m_axis_tready) |=> mvalid_q && $stable(rv_q) && $stable(st_q))
    else $error("pending result word changed");

endmodule
